@@ src/ilpp_pkg.sv @@
package ilpp_pkg;

    localparam int OFFSET_BITS = 30;
    localparam int PADDR_BITS  = 4;

    // register byte addresses
    localparam logic [PADDR_BITS-1:0] ADDR_OLD_HASH    = 4'h0;
    localparam logic [PADDR_BITS-1:0] ADDR_NEW_HASH    = 4'h4;
    localparam logic [PADDR_BITS-1:0] ADDR_REPORT_ONLY = 4'h8;

    // instruction encodings
    localparam logic [31:0] UPPER_OPCODE    = 32'h1400_0000;
    localparam logic [31:0] UPPER_OPC_MASK  = 32'hffff_ffe0;
    localparam logic [31:0] ORI_OPCODE      = 32'h0380_0000;
    localparam logic [31:0] UPPER_KEEP_MASK = 32'hfe00_001f;
    localparam logic [31:0] ORI_KEEP_MASK   = 32'hffc0_03ff;

    typedef struct packed {
        logic [31:0]            insn_word;
        logic [OFFSET_BITS-1:0] word_offset;
        logic                   section_end;
    } in_beat_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] upper_offset;
        logic [31:0]            upper_old;
        logic [31:0]            upper_new;
        logic [OFFSET_BITS-1:0] lower_offset;
        logic [31:0]            lower_old;
        logic [31:0]            lower_new;
        logic                   is_report;
    } out_beat_t;

    typedef struct packed {
        logic [31:0] old_hash;
        logic [31:0] new_hash;
        logic        report_only;
    } cfg_t;

endpackage

@@ src/ilpp_regs.sv @@
module ilpp_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ilpp_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output ilpp_pkg::cfg_t                   cfg
);

    logic [31:0] old_hash_reg;
    logic [31:0] new_hash_reg;
    logic        report_only_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            old_hash_reg    <= '0;
            new_hash_reg    <= '0;
            report_only_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr)
                ilpp_pkg::ADDR_OLD_HASH:    old_hash_reg    <= pwdata;
                ilpp_pkg::ADDR_NEW_HASH:    new_hash_reg    <= pwdata;
                ilpp_pkg::ADDR_REPORT_ONLY: report_only_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ilpp_pkg::ADDR_OLD_HASH:    prdata = old_hash_reg;
            ilpp_pkg::ADDR_NEW_HASH:    prdata = new_hash_reg;
            ilpp_pkg::ADDR_REPORT_ONLY: prdata = {31'd0, report_only_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.old_hash    = old_hash_reg;
    assign cfg.new_hash    = new_hash_reg;
    assign cfg.report_only = report_only_reg;

endmodule

@@ src/ilpp_scan.sv @@
module ilpp_scan (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ilpp_pkg::cfg_t        cfg,
    input  logic                  step,
    input  ilpp_pkg::in_beat_t    beat,
    output logic                  hit,
    output ilpp_pkg::out_beat_t   result
);

    logic                             pending_reg;
    logic                             pending_next;
    logic [4:0]                       preg_reg;
    logic [4:0]                       preg_next;
    logic [31:0]                      saved_word_reg;
    logic [31:0]                      saved_word_next;
    logic [ilpp_pkg::OFFSET_BITS-1:0] saved_off_reg;
    logic [ilpp_pkg::OFFSET_BITS-1:0] saved_off_next;

    logic [31:0] upper_want;
    logic [31:0] ori_want;
    logic        upper_match;
    logic        ori_match;
    logic        clobber;

    assign upper_want  = ilpp_pkg::UPPER_OPCODE | {7'd0, cfg.old_hash[31:12], 5'd0};
    assign ori_want    = ilpp_pkg::ORI_OPCODE | {10'd0, cfg.old_hash[11:0], preg_reg, preg_reg};
    assign upper_match = (beat.insn_word & ilpp_pkg::UPPER_OPC_MASK) == upper_want;
    assign ori_match   = beat.insn_word == ori_want;
    assign clobber     = beat.insn_word[4:0] == preg_reg;

    assign hit = pending_reg && ori_match;

    always_comb
    begin
        result.upper_offset = saved_off_reg;
        result.upper_old    = saved_word_reg;
        result.upper_new    = (saved_word_reg & ilpp_pkg::UPPER_KEEP_MASK)
                              | {7'd0, cfg.new_hash[31:12], 5'd0};
        result.lower_offset = beat.word_offset;
        result.lower_old    = beat.insn_word;
        result.lower_new    = (beat.insn_word & ilpp_pkg::ORI_KEEP_MASK)
                              | {10'd0, cfg.new_hash[11:0], 10'd0};
        result.is_report    = cfg.report_only;
    end

    always_comb
    begin
        pending_next    = pending_reg;
        preg_next       = preg_reg;
        saved_word_next = saved_word_reg;
        saved_off_next  = saved_off_reg;
        if (!pending_reg)
        begin
            if (upper_match)
            begin
                pending_next    = 1'b1;
                preg_next       = beat.insn_word[4:0];
                saved_word_next = beat.insn_word;
                saved_off_next  = beat.word_offset;
            end
        end
        else if (ori_match || clobber)
        begin
            pending_next = 1'b0;
            preg_next    = '0;
        end
        if (beat.section_end)
        begin
            pending_next = 1'b0;
            preg_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            preg_reg    <= '0;
        end
        else if (step)
        begin
            pending_reg <= pending_next;
            preg_reg    <= preg_next;
        end
    end

    // saved upper word is only looked at while a match is pending
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            saved_word_reg <= saved_word_next;
            saved_off_reg  <= saved_off_next;
        end
    end

endmodule

@@ src/immediate_load_pair_patcher_top.sv @@
// immediate load pair patcher: watches a stream of 32-bit instruction words
// for an upper-immediate load of old_hash bits 31..12 followed, later in the
// same section, by an or-immediate of old_hash bits 11..0 with the loaded
// register as source and destination, and emits one record per such pair
// carrying both offsets, both original words and both words rewritten with
// new_hash. one input beat is taken every cycle unless a record waits
// untaken in the output register: each beat is latched in an input
// register, checked against the single pending-match register set, and
// any record lands in an output register, which holds it until taken.
// a section_end beat is scanned normally and then drops any pending
// match. old_hash, new_hash and report_only sit at byte addresses 0, 4 and 8
// of the apb port and are to be written only while the block is idle.
module immediate_load_pair_patcher_top (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             in_valid,
    output logic                             in_ready,
    input  ilpp_pkg::in_beat_t               in_data,
    // result records
    output logic                             out_valid,
    input  logic                             out_ready,
    output ilpp_pkg::out_beat_t              out_data,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ilpp_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    ilpp_pkg::cfg_t      cfg;
    ilpp_pkg::in_beat_t  in_beat_reg;
    ilpp_pkg::out_beat_t out_beat_reg;
    ilpp_pkg::out_beat_t result;
    logic                in_vld_reg;
    logic                out_vld_reg;
    logic                hit;
    logic                step;

    ilpp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the latched beat moves on when the output register has room for
    // whatever record it may produce
    assign step     = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || step;

    ilpp_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (step),
        .beat   (in_beat_reg),
        .hit    (hit),
        .result (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_beat_reg <= in_data;
        end
    end

    // output register: loads on a hit, empties when the record is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (step && hit)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && hit)
        begin
            out_beat_reg <= result;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_beat_reg;

endmodule
